@@ rtl/core/rational_add_multiply_defines.svh @@
// Assertion macros used by the port-level checker.
// Each macro expects clk to be visible at the point of use, the first two rst as well.
`ifndef RATIONAL_ADD_MULTIPLY_DEFINES_SVH
`define RATIONAL_ADD_MULTIPLY_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define RATAM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is high.
`define RATAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define RATAM_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ratam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratam_pkg
// Types, constants and helper functions of the rational add / multiply unit.
// ----------------------------------------------------------------------------
package ratam_pkg;

  localparam int WORD_BITS = 32;
  localparam int HALF_BITS = WORD_BITS / 2;
  localparam int LEN_W     = 5;
  localparam int SHIFT_W   = 5;

  // Any bit from 15 up in the combined magnitude triggers a scale down.
  localparam logic [WORD_BITS-1:0] SHRINK_TRIGGER = 32'hffff8000;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [LEN_W-1:0]     len_t;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_MUL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t an;
    word_t ad;
    word_t bn;
    word_t bd;
  } operands_t;

  // Item between scaling stages.
  typedef struct packed {
    cmd_t  cmd;
    logic  same_den;
    word_t an;
    word_t ad;
    word_t bn;
    word_t bd;
    len_t  lbd;
  } scale_item_t;

  typedef struct packed {
    word_t n;
    word_t d;
  } frac_t;

  typedef struct packed {
    logic a;
    logic b;
  } shrink_sel_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t den;
  } prod_item_t;

  function automatic word_t mag(input word_t x);
    return x[WORD_BITS-1] ? word_t'(-x) : x;
  endfunction

  // Length of the magnitude (index of the highest set bit plus one), bit 31 ignored.
  function automatic len_t bit_len(input word_t x);
    word_t m;
    len_t  r;
    m = mag(x);
    r = '0;
    for (int i = 0; i < WORD_BITS - 1; i++) begin
      if (m[i]) r = len_t'(i + 1);
    end
    return r;
  endfunction

  function automatic word_t div_pow2(input word_t x, input logic [SHIFT_W-1:0] s);
    word_t m;
    m = mag(x) >> s;
    return x[WORD_BITS-1] ? word_t'(-m) : m;
  endfunction

  function automatic frac_t shrink(input word_t n, input word_t d);
    word_t               c;
    int                  k;
    logic [SHIFT_W-1:0]  s;
    frac_t               f;
    c = mag(n) | mag(d);
    k = 16;
    for (int p = 7; p <= 15; p++) begin
      if (c[2*p] || c[2*p-1]) k = p;
    end
    s = SHIFT_W'(2 * (k - 7));
    if ((c & SHRINK_TRIGGER) == '0) begin
      f.n = n;
      f.d = d;
    end else begin
      f.n = div_pow2(n, s);
      f.d = div_pow2(d, s);
    end
    return f;
  endfunction

  // Overflow check on one operand pair.
  function automatic shrink_sel_t check_pair(input len_t lx, input len_t ly, input logic en);
    logic        over;
    shrink_sel_t sel;
    over  = ({1'b0, lx} + {1'b0, ly}) >= (LEN_W + 1)'(WORD_BITS);
    sel.a = en && over && (lx >= len_t'(HALF_BITS));
    sel.b = en && over && (ly >= len_t'(HALF_BITS));
    return sel;
  endfunction

endpackage

@@ rtl/core/ratam_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratam_scale
// Three register stages, one overflow check with operand scaling each.
// ----------------------------------------------------------------------------
module ratam_scale
  import ratam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  operands_t   in_op,
  output logic        out_valid,
  input  logic        out_ready,
  output scale_item_t out_item
);

  logic        v1, v2, v3;
  logic        ready1, ready2, ready3;
  scale_item_t s1, s2, s3;
  scale_item_t s1_next, s2_next, s3_next;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Stage 1: mul checks the numerators, add checks a_num against b_den.
  always_comb begin
    shrink_sel_t sel;
    frac_t       fa, fb;
    len_t        lx, ly;
    s1_next.cmd      = in_op.cmd;
    s1_next.same_den = (in_op.cmd == CMD_ADD) && (in_op.ad == in_op.bd);
    lx  = bit_len(in_op.an);
    ly  = bit_len((in_op.cmd == CMD_MUL) ? in_op.bn : in_op.bd);
    sel = check_pair(lx, ly, !s1_next.same_den);
    fa  = shrink(in_op.an, in_op.ad);
    fb  = shrink(in_op.bn, in_op.bd);
    s1_next.an  = sel.a ? fa.n : in_op.an;
    s1_next.ad  = sel.a ? fa.d : in_op.ad;
    s1_next.bn  = sel.b ? fb.n : in_op.bn;
    s1_next.bd  = sel.b ? fb.d : in_op.bd;
    s1_next.lbd = '0;
  end

  // Stage 2: mul checks the denominators, add checks a_den against b_num.
  // The b_den length seen here is the one the last add check reuses.
  always_comb begin
    shrink_sel_t sel;
    frac_t       fa, fb;
    len_t        lx, ly;
    s2_next.cmd      = s1.cmd;
    s2_next.same_den = s1.same_den;
    s2_next.lbd      = bit_len(s1.bd);
    lx  = bit_len(s1.ad);
    ly  = (s1.cmd == CMD_MUL) ? s2_next.lbd : bit_len(s1.bn);
    sel = check_pair(lx, ly, !s1.same_den);
    fa  = shrink(s1.an, s1.ad);
    fb  = shrink(s1.bn, s1.bd);
    s2_next.an = sel.a ? fa.n : s1.an;
    s2_next.ad = sel.a ? fa.d : s1.ad;
    s2_next.bn = sel.b ? fb.n : s1.bn;
    s2_next.bd = sel.b ? fb.d : s1.bd;
  end

  // Stage 3: add only, a_den against the held b_den length.
  always_comb begin
    shrink_sel_t sel;
    frac_t       fa, fb;
    s3_next = s2;
    sel = check_pair(bit_len(s2.ad), s2.lbd, (s2.cmd == CMD_ADD) && !s2.same_den);
    fa  = shrink(s2.an, s2.ad);
    fb  = shrink(s2.bn, s2.bd);
    if (sel.a) begin
      s3_next.an = fa.n;
      s3_next.ad = fa.d;
    end
    if (sel.b) begin
      s3_next.bn = fb.n;
      s3_next.bd = fb.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) s1 <= s1_next;
    if (ready2) s2 <= s2_next;
    if (ready3) s3 <= s3_next;
  end

  assign out_valid = v3;
  assign out_item  = s3;

endmodule

@@ rtl/core/ratam_product.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratam_product
// Multiply stage followed by the final sum stage, which is the output register.
// ----------------------------------------------------------------------------
module ratam_product
  import ratam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  scale_item_t in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       out_num,
  output word_t       out_den
);

  logic       pv, ov;
  logic       p_ready, o_ready;
  prod_item_t p, p_next;
  word_t      m1, m2, mdd;

  assign o_ready  = !ov || out_ready;
  assign p_ready  = !pv || o_ready;
  assign in_ready = p_ready;

  // num = x + y; equal-denominator add bypasses the products.
  always_comb begin
    m1  = in_item.an * ((in_item.cmd == CMD_MUL) ? in_item.bn : in_item.bd);
    m2  = in_item.ad * in_item.bn;
    mdd = in_item.ad * in_item.bd;
    if (in_item.same_den) begin
      p_next.x   = in_item.an;
      p_next.y   = in_item.bn;
      p_next.den = in_item.ad;
    end else begin
      p_next.x   = m1;
      p_next.y   = (in_item.cmd == CMD_MUL) ? '0 : m2;
      p_next.den = mdd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (p_ready) pv <= in_valid;
      if (o_ready) ov <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready) p <= p_next;
    if (o_ready) begin
      out_num <= p.x + p.y;
      out_den <= p.den;
    end
  end

  assign out_valid = ov;

endmodule

@@ rtl/core/rational_add_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_multiply
// Add or multiply two signed 32-bit fractions with pre-scaling against overflow.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while s_tready is high and returns one
// result per request, in order. The path runs through five register stages:
// three overflow checks that scale operands down by an even power of two, one
// stage of 32x32 multipliers (low word kept), and the final sum, which doubles
// as the output register. A stall on the output backs up stage by stage;
// bubbles are squeezed out, so the pipeline holds up to five requests. Products
// and sums wrap at 32 bits; an add with bit-identical denominators just sums
// the numerators.
module rational_add_multiply
  import ratam_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Request side
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic         s_tuser,   // command: 0 add, 1 multiply
  // Result side
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata    // res_num[31:0], res_den[63:32]
);

  operands_t   op;
  scale_item_t scaled;
  logic        scaled_valid;
  logic        scaled_ready;
  word_t       res_num;
  word_t       res_den;

  // Unpack the request.
  assign op.cmd = cmd_t'(s_tuser);
  assign op.an  = s_tdata[31:0];
  assign op.ad  = s_tdata[63:32];
  assign op.bn  = s_tdata[95:64];
  assign op.bd  = s_tdata[127:96];

  // Stages 1-3: overflow checks and scaling.
  ratam_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (op),
    .out_valid (scaled_valid),
    .out_ready (scaled_ready),
    .out_item  (scaled)
  );

  // Stages 4-5: products, then the final sum into the output register.
  ratam_product u_product (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scaled_valid),
    .in_ready  (scaled_ready),
    .in_item   (scaled),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_num   (res_num),
    .out_den   (res_den)
  );

  assign m_tdata = {res_den, res_num};

endmodule

@@ rtl/core/ratam_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratam_checker
// Port-level assertions for the rational add / multiply unit.
// ----------------------------------------------------------------------------
`include "rational_add_multiply_defines.svh"

module ratam_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // Accepted requests, shifted along while the result side keeps taking;
  // bit 4 marks one that has moved through the whole register with no stall or reset since.
  logic [4:0] acc_hist;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_hist <= '0;
    end else begin
      acc_hist <= {acc_hist[3:0] & {4{m_tready}}, s_tvalid && s_tready};
    end
  end

  `RATAM_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid, "result valid after reset")

  `RATAM_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held")

  // An empty or draining output stage lets the whole pipeline advance.
  `RATAM_ASSERT_IMPL(a_ready_chain, !m_tvalid || m_tready, s_tready, "request side blocked")

  // Without stalls or reset, a request that reaches bit 4 of the history shows up as a valid result.
  `RATAM_ASSERT_IMPL(a_latency, acc_hist[4], m_tvalid, "result missing after five cycles")

endmodule

bind rational_add_multiply ratam_checker u_ratam_checker (.*);

@@ test/rational_add_multiply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_multiply_checker
// Watches both stream channels of the fraction unit, computes the expected
// fraction for every accepted request and compares it with each result.
// ----------------------------------------------------------------------------
module rational_add_multiply_checker
  import ratam_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic         s_tuser,   // command: 0 add, 1 multiply
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,   // res_num[31:0], res_den[63:32]
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [31:0] n;
    logic [31:0] d;
  } ratio_t;

  ratio_t fraction_q[$];
  int     mismatches = 0;

  function automatic logic [31:0] magn(input logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

  // Length of the magnitude (index of the highest set bit plus one), bit 31 left out.
  function automatic int bits_used(input logic [31:0] x);
    logic [31:0] m;
    int          r;
    m = magn(x) & 32'h7fffffff;
    r = 0;
    for (int i = 0; i < 31; i++) begin
      if (m[i]) r = i + 1;
    end
    return r;
  endfunction

  // Divide by 2^s, truncating toward zero.
  function automatic logic [31:0] scale_pow2(input logic [31:0] x, input int s);
    logic [31:0] m;
    m = magn(x) >> s;
    return x[31] ? 32'd0 - m : m;
  endfunction

  function automatic ratio_t reduce(input ratio_t f);
    logic [31:0] c;
    int          k;
    c = magn(f.n) | magn(f.d);
    k = 0;
    if ((c & SHRINK_TRIGGER) == 32'd0) return f;
    for (int p = 15; p >= 7; p--) begin
      if (k == 0 && (c[2*p] || c[2*p-1])) k = p;
    end
    if (k == 0) k = 16;  // only bit 31 set above bit 12
    f.n = scale_pow2(f.n, 2 * (k - 7));
    f.d = scale_pow2(f.d, 2 * (k - 7));
    return f;
  endfunction

  function automatic ratio_t combine_fractions(input cmd_t op, input ratio_t a,
                                               input ratio_t b);
    int     la;
    int     lb;
    int     lad;
    int     lbd;
    ratio_t r;
    if (op == CMD_MUL) begin
      la = bits_used(a.n);
      lb = bits_used(b.n);
      if (la + lb >= WORD_BITS) begin
        if (la >= HALF_BITS) a = reduce(a);
        if (lb >= HALF_BITS) b = reduce(b);
      end
      la = bits_used(a.d);
      lb = bits_used(b.d);
      if (la + lb >= WORD_BITS) begin
        if (la >= HALF_BITS) a = reduce(a);
        if (lb >= HALF_BITS) b = reduce(b);
      end
      r.n = a.n * b.n;
      r.d = a.d * b.d;
    end else if (a.d == b.d) begin
      r.n = a.n + b.n;
      r.d = a.d;
    end else begin
      // a_num against b_den; b_den is measured again after its own scaling
      la  = bits_used(a.n);
      lbd = bits_used(b.d);
      if (la + lbd >= WORD_BITS) begin
        if (la >= HALF_BITS) a = reduce(a);
        if (lbd >= HALF_BITS) begin
          b   = reduce(b);
          lbd = bits_used(b.d);
        end
      end
      // a_den against b_num
      lad = bits_used(a.d);
      lb  = bits_used(b.n);
      if (lad + lb >= WORD_BITS) begin
        if (lad >= HALF_BITS) begin
          a   = reduce(a);
          lad = bits_used(a.d);
        end
        if (lb >= HALF_BITS) b = reduce(b);
      end
      // the denominators, with lengths as last measured
      if (lad + lbd >= WORD_BITS) begin
        if (lad >= HALF_BITS) a = reduce(a);
        if (lbd >= HALF_BITS) b = reduce(b);
      end
      r.n = a.n * b.d + a.d * b.n;
      r.d = a.d * b.d;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ratio_t a;
    ratio_t b;
    ratio_t want;
    ratio_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        a.n = s_tdata[31:0];
        a.d = s_tdata[63:32];
        b.n = s_tdata[95:64];
        b.d = s_tdata[127:96];
        fraction_q.push_back(combine_fractions(cmd_t'(s_tuser), a, b));
      end
      if (m_tvalid && m_tready) begin
        got.n = m_tdata[31:0];
        got.d = m_tdata[63:32];
        if (fraction_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: num %h den %h",
                     $realtime, got.n, got.d);
        end else begin
          want = fraction_q.pop_front();
          if (got.n !== want.n || got.d !== want.d) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected num %h den %h, got num %h den %h",
                       $realtime, want.n, want.d, got.n, got.d);
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= fraction_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random add / multiply requests into the fraction unit
// with random idling on both sides and one long output stall; the checker
// beside the block predicts every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ratam_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_ITEMS  = 617;   // three phases, about 1850 random requests
  localparam int DRAIN_CYCLES = 20;    // the block has five register stages

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata  = '0;   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  logic         s_tuser  = 1'b0; // command: 0 add, 1 multiply
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;         // res_num[31:0], res_den[63:32]

  int   errors;
  int   pending;
  int   cycles        = 0;
  int   send_idle_pct = 16;  // chance per cycle that no request is offered
  int   recv_idle_pct = 55;  // chance per cycle that the result side stalls
  logic hold_off      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rational_add_multiply dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rational_add_multiply_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Result side: random stalls, forced low for the whole hold-off stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long output stall early in the random part; the sender keeps
  // offering, so the five-deep pipeline fills and s_tready drops.
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and return at
  // the edge where it is taken. tvalid stays high when the next request
  // follows back to back.
  task automatic send_request(input cmd_t op, input logic [31:0] an,
                              input logic [31:0] ad, input logic [31:0] bn,
                              input logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bd, bn, ad, an};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Random operand: mostly a chosen magnitude width with its top bit often
  // set, so the lengths around the 16 / 32 thresholds come up a lot; a
  // quarter are plain random words. -2^31 is not a legal operand.
  function automatic logic [31:0] rand_operand();
    int          w;
    logic [31:0] v;
    if ($urandom_range(3) == 0) begin
      v = $urandom;
      if (v == 32'h80000000) v = 32'h7fffffff;
      return v;
    end
    w = $urandom_range(31);
    v = (w == 0) ? 32'd0 : ($urandom & ((32'd1 << w) - 32'd1));
    if (w > 0 && $urandom_range(1)) v[w-1] = 1'b1;
    if ($urandom_range(1)) v = 32'd0 - v;
    return v;
  endfunction

  initial begin : stimulus
    cmd_t        op;
    logic [31:0] ad;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: small values, field extremes, the scaling
    // thresholds, shared denominators and zero denominators.
    send_request(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_request(CMD_MUL, 32'd1, 32'd2, 32'd1, 32'd3);
    send_request(CMD_ADD, 32'h7fffffff, 32'h7fffffff, 32'h80000001, 32'h7fffffff);
    send_request(CMD_ADD, 32'h7fffffff, 32'd1, 32'h7fffffff, 32'd3);
    send_request(CMD_ADD, 32'h80000001, 32'h80000001, 32'h7fffffff, 32'h7fffffff);
    send_request(CMD_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_request(CMD_MUL, 32'h80000001, 32'h80000001, 32'h80000001, 32'h7fffffff);
    send_request(CMD_MUL, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(CMD_ADD, 32'd5, 32'd0, 32'd7, 32'd3);
    send_request(CMD_ADD, 32'h00008000, 32'd1, 32'd1, 32'h00010000);
    send_request(CMD_MUL, 32'h00008000, 32'd1, 32'h00008000, 32'd1);
    send_request(CMD_MUL, 32'h0000ffff, 32'd3, 32'hffff0001, 32'd5);
    send_request(CMD_MUL, 32'h00007fff, 32'h00007fff, 32'h0001ffff, 32'h0001ffff);
    send_request(CMD_MUL, 32'h40000000, 32'd3, 32'd2, 32'd5);
    send_request(CMD_ADD, 32'hffffffff, 32'hffffffff, 32'd1, 32'd1);
    send_request(CMD_ADD, 32'h00010000, 32'h7fffffff, 32'h00010000, 32'h7ffffffe);
    send_request(CMD_ADD, 32'h12345678, 32'd7, 32'd9, 32'h0abcdef0);
    send_request(CMD_ADD, 32'd11, 32'h6543210f, 32'hedcba988, 32'd13);
    send_request(CMD_MUL, 32'h00004000, 32'h00060000, 32'h00020000, 32'hfff00001);
    send_request(CMD_ADD, 32'h00006000, 32'h00018000, 32'h00000100, 32'h00000200);
    send_request(CMD_MUL, 32'h00000001, 32'h80000001, 32'h00000001, 32'h00000002);

    // Random part in three phases, the last without idling.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 16; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (PHASE_ITEMS) begin
        op = cmd_t'($urandom_range(1));
        ad = rand_operand();
        // shared denominators take the add shortcut
        if (op == CMD_ADD && $urandom_range(4) == 0)
          send_request(op, rand_operand(), ad, rand_operand(), ad);
        else
          send_request(op, rand_operand(), ad, rand_operand(), rand_operand());
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
